@@ rtl/pftr_pkg.sv @@
package pftr_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_NEWLINE,
      ST_FETCH,
      ST_SEND
   } state_type;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_RENDER  = 2'd1,
      ACT_RESTART = 2'd2
   } action_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  char_code;
      logic [8:0]  glyph_row_index;
      logic [31:0] glyph_row_bits;
   } req_type;

   typedef struct packed {
      logic [15:0] row_address;
      logic [31:0] plane_bytes;
      logic        out_of_range;
      logic        last_row;
   } rsp_type;

   localparam int unsigned GLYPH_W    = 6;
   localparam int unsigned ROW_W      = 3;
   localparam int unsigned OFFSET_W   = 16;
   localparam int unsigned LINE_ROWS  = 10;

   localparam logic [ROW_W-1:0]   LAST_ROW = 3'd7;
   localparam logic [GLYPH_W-1:0] NO_GLYPH = 6'd39;

   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_Z      = 8'h5A;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_PERIOD = 8'h2E;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_BANG   = 8'h21;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   localparam logic [GLYPH_W-1:0] GLYPH_DIGIT0 = 6'd26;
   localparam logic [GLYPH_W-1:0] GLYPH_PERIOD = 6'd36;
   localparam logic [GLYPH_W-1:0] GLYPH_COMMA  = 6'd37;
   localparam logic [GLYPH_W-1:0] GLYPH_BANG   = 6'd38;

   function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] code);
      logic [GLYPH_W-1:0] glyph;
      glyph = NO_GLYPH;
      if (code inside {[CHAR_A:CHAR_Z]}) begin
         glyph = GLYPH_W'(code - CHAR_A);
      end else if (code inside {[CHAR_0:CHAR_9]}) begin
         glyph = GLYPH_W'(code - CHAR_0) + GLYPH_DIGIT0;
      end else if (code == CHAR_PERIOD) begin
         glyph = GLYPH_PERIOD;
      end else if (code == CHAR_COMMA) begin
         glyph = GLYPH_COMMA;
      end else if (code == CHAR_BANG) begin
         glyph = GLYPH_BANG;
      end
      return glyph;
   endfunction

endpackage

@@ rtl/pftr_glyph_ram.sv @@
module pftr_glyph_ram #(
   parameter int unsigned DEPTH = 320,
   parameter int unsigned WIDTH = 32,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/planar_font_text_renderer.sv @@
// Text renderer for a four-plane interleaved framebuffer. A load transfer writes one glyph
// row to the internal glyph store if its index is in range; a restart zeroes the cursor and
// line start. A render transfer is handled by a small sequencer around one shared 17-bit
// adder, which in turn advances the cursor, steps the line start on carriage return and
// walks the row address down the glyph: a character with no glyph only advances the cursor,
// carriage return also steps the line start, and a drawn glyph sends its rows. The glyph
// store has one read port with registered data, read once per row. Input is not taken while
// a character is in progress. Glyph rows that were never loaded read back as unknown data.
module planar_font_text_renderer #(
   parameter int unsigned LINE_PITCH  = 160,
   parameter int unsigned FRAME_BYTES = 32000,
   parameter int unsigned GLYPH_COUNT = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pftr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pftr_pkg::rsp_type rsp_payload
);

   localparam int unsigned STORE_DEPTH = GLYPH_COUNT * 8;
   localparam int unsigned AW          = $clog2(STORE_DEPTH);
   localparam int unsigned SUM_W       = pftr_pkg::OFFSET_W + 1;
   localparam int unsigned IDX_W       = pftr_pkg::GLYPH_W + pftr_pkg::ROW_W;

   localparam logic [SUM_W-1:0] PITCH_STEP = SUM_W'(LINE_PITCH);
   localparam logic [SUM_W-1:0] LINE_STEP  = SUM_W'(pftr_pkg::LINE_ROWS * LINE_PITCH);
   localparam logic [SUM_W-1:0] OOR_LIMIT  = SUM_W'(FRAME_BYTES - 6);
   localparam logic [9:0]       DEPTH_LIM  = 10'(STORE_DEPTH);
   localparam logic [15:0]      PITCH16    = 16'(LINE_PITCH);

   pftr_pkg::state_type state_ff, state_in;

   logic [pftr_pkg::OFFSET_W-1:0] cursor_ff, cursor_in;
   logic [pftr_pkg::OFFSET_W-1:0] line_start_ff, line_start_in;
   logic [SUM_W-1:0]              addr_ff, addr_in;
   logic [pftr_pkg::GLYPH_W-1:0]  glyph_ff, glyph_in;
   logic [pftr_pkg::ROW_W-1:0]    row_ff, row_in;
   logic                          cr_ff, cr_in;

   logic             req_xfer;
   logic             rsp_xfer;
   logic [SUM_W-1:0] sum_a;
   logic [SUM_W-1:0] sum_b;
   logic [SUM_W-1:0] sum;

   logic             wr_en;
   logic             rd_en;
   logic [IDX_W-1:0] rd_idx;
   logic [31:0]      rd_data;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // the one shared adder
   assign sum = sum_a + sum_b;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pftr_pkg::ST_IDLE: begin
            if (req_xfer && req_payload.action == pftr_pkg::ACT_RENDER) begin
               state_in = pftr_pkg::ST_ADVANCE;
            end
         end
         pftr_pkg::ST_ADVANCE: begin
            if (cr_ff) begin
               state_in = pftr_pkg::ST_NEWLINE;
            end else if (glyph_ff == pftr_pkg::NO_GLYPH) begin
               state_in = pftr_pkg::ST_IDLE;
            end else begin
               state_in = pftr_pkg::ST_FETCH;
            end
         end
         pftr_pkg::ST_NEWLINE: state_in = pftr_pkg::ST_IDLE;
         pftr_pkg::ST_FETCH:   state_in = pftr_pkg::ST_SEND;
         pftr_pkg::ST_SEND: begin
            if (rsp_ready && row_ff == pftr_pkg::LAST_ROW) begin
               state_in = pftr_pkg::ST_IDLE;
            end
         end
         default: state_in = pftr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cursor_in     = cursor_ff;
      line_start_in = line_start_ff;
      addr_in       = addr_ff;
      glyph_in      = glyph_ff;
      row_in        = row_ff;
      cr_in         = cr_ff;
      sum_a         = addr_ff;
      sum_b         = PITCH_STEP;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_idx        = {glyph_ff, row_ff};
      case (state_ff)
         pftr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_xfer) begin
               case (req_payload.action)
                  pftr_pkg::ACT_LOAD: begin
                     wr_en = ({1'b0, req_payload.glyph_row_index} < DEPTH_LIM);
                  end
                  pftr_pkg::ACT_RENDER: begin
                     glyph_in = pftr_pkg::glyph_of(req_payload.char_code);
                     cr_in    = (req_payload.char_code == pftr_pkg::CHAR_CR);
                     addr_in  = {1'b0, cursor_ff};
                  end
                  pftr_pkg::ACT_RESTART: begin
                     cursor_in     = '0;
                     line_start_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         pftr_pkg::ST_ADVANCE: begin
            // odd cursor skips over the other three planes' words
            sum_a     = {1'b0, cursor_ff};
            sum_b     = cursor_ff[0] ? SUM_W'(7) : SUM_W'(1);
            cursor_in = sum[pftr_pkg::OFFSET_W-1:0];
            row_in    = '0;
         end
         pftr_pkg::ST_NEWLINE: begin
            sum_a         = {1'b0, line_start_ff};
            sum_b         = LINE_STEP;
            line_start_in = sum[pftr_pkg::OFFSET_W-1:0];
            cursor_in     = sum[pftr_pkg::OFFSET_W-1:0];
         end
         pftr_pkg::ST_FETCH: begin
            rd_en = 1'b1;
         end
         pftr_pkg::ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready && row_ff != pftr_pkg::LAST_ROW) begin
               // fetch the next row while this one is transferred
               row_in  = row_ff + 1'b1;
               addr_in = sum;
               rd_en   = 1'b1;
               rd_idx  = {glyph_ff, row_in};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pftr_pkg::ST_IDLE;
         cursor_ff     <= '0;
         line_start_ff <= '0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         line_start_ff <= line_start_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      glyph_ff <= glyph_in;
      row_ff   <= row_in;
      cr_ff    <= cr_in;
   end

   pftr_glyph_ram #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (32),
      .AW    (AW)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_payload.glyph_row_index[AW-1:0]),
      .wr_data (req_payload.glyph_row_bits),
      .rd_en   (rd_en),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_payload.row_address  = addr_ff[pftr_pkg::OFFSET_W-1:0];
   assign rsp_payload.plane_bytes  = rd_data;
   assign rsp_payload.out_of_range = (addr_ff >= OOR_LIMIT);
   assign rsp_payload.last_row     = (row_ff == pftr_pkg::LAST_ROW);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a row write is pending");

   a_end_of_glyph: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_payload.last_row) |=> !rsp_valid)
      else $error("row write after the last row of a glyph");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_payload.last_row) |=>
         (rsp_valid && rsp_payload.row_address == $past(rsp_payload.row_address) + PITCH16))
      else $error("row address did not advance by one line");

endmodule
